// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of this project.
// Depends on nothing; HUX_ASSERT expects clk and rst_n in scope, HUX_ASSERT_ALWAYS only clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define HUX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define HUX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/hux_pkg.sv =====
// Shared types and constants of the Huffman bit packer.
// Depends on nothing; every module file of the design uses it by scoped names.
package hux_pkg;

  localparam int SYMBOLS      = 128;
  localparam int SYM_W        = 7;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int MAX_CODE_LEN = 32;
  localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int BYTE_W       = 8;
  localparam int ACC_W        = CODE_W + BYTE_W;
  localparam int PC_W         = 4;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = 2;
  localparam int Q_CNT_W      = 3;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_ENCODE = 2'd1;
  localparam logic [1:0] ACT_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  code_length;
    logic [CODE_W-1:0] code_bits;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_pad_count;
    logic              last_of_run;
  } out_item_t;

  // One queued job: a flush, or a code left-aligned in code_left.
  typedef struct packed {
    logic              is_flush;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code_left;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SHIFT,
    BK_PAD
  } back_state_t;

endpackage

// ===== design/huffman_bit_packer.sv =====
// Huffman bit packer: top level joining front end, job queue and back end.
// Depends on hux_pkg, hux_front, hux_queue and hux_back.
//
// Usage: the input channel (in_valid, in_stall, in_item) takes one transaction
// per cycle while in_stall is low, of three kinds. A load writes a symbol's code
// length and code bits into the 128-entry table and produces nothing. An encode
// appends the symbol's code, most significant bit first, and releases a byte for
// every eight bits beyond the eight that stay pending. A flush sends the
// zero-padded last byte and then the pad count. The result channel (out_valid,
// out_stall, out_item) carries one byte per transaction; last_of_run marks the
// final byte of an input item. With the queue empty, an encode's first byte
// passes the table read registers, a queue entry, the accumulator and the output
// register before it shows on the result port; a flush's padded byte skips the
// accumulator. The back end merges an encode, then sends its bytes one at a time;
// a load occupies only the front end. The four-entry job queue lets loads and new
// items keep arriving while bytes drain. When the receiver stalls, the output
// register holds its transaction, the back end waits to send, and in_stall rises
// once the queue fills. Reset empties the queue and pending bits and marks every
// table entry as length zero; there is no clearing pass.
module huffman_bit_packer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hux_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output hux_pkg::out_item_t  out_item
);

  hux_pkg::q_status_t q_status;
  hux_pkg::job_t      push_job;
  hux_pkg::job_t      head;
  logic               push;
  logic               pop;

  // Front end: table lookup and job classification.
  hux_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  // Job queue decouples table access from byte output.
  hux_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  // Back end: bit packing, byte output and flush handling.
  hux_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== design/hux_front.sv =====
// Front end: accepts transactions, owns the code table, and queues jobs.
// Depends on hux_pkg.
module hux_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hux_pkg::in_item_t   in_item,
  input  hux_pkg::q_status_t  q_status,
  output logic                push,
  output hux_pkg::job_t       push_job
);

  logic [hux_pkg::LEN_W-1:0]  len_mem [hux_pkg::SYMBOLS];
  logic [hux_pkg::CODE_W-1:0] code_mem [hux_pkg::SYMBOLS];
  logic [hux_pkg::SYMBOLS-1:0] vld_r, vld_nxt;

  logic pend_r, pend_nxt;
  logic pflush_r, pflush_nxt;
  logic rd_vld_r;
  logic [hux_pkg::LEN_W-1:0]  rd_len_r;
  logic [hux_pkg::CODE_W-1:0] rd_code_r;

  logic accept, is_load, is_encode, is_flush;
  logic [hux_pkg::LEN_W-1:0] len_sat, len_eff;

  assign in_stall = pend_r && q_status.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    is_load   = 1'b0;
    is_encode = 1'b0;
    is_flush  = 1'b0;
    unique case (in_item.action)
      hux_pkg::ACT_LOAD:   is_load   = 1'b1;
      hux_pkg::ACT_ENCODE: is_encode = 1'b1;
      hux_pkg::ACT_FLUSH:  is_flush  = 1'b1;
      default: ;
    endcase
  end

  // Over-long codes are stored clipped to the supported length.
  assign len_sat = (in_item.code_length > hux_pkg::LEN_W'(hux_pkg::LEN_CAP)) ?
                   hux_pkg::LEN_W'(hux_pkg::LEN_CAP) : in_item.code_length;

  always_ff @(posedge clk) begin
    if (accept && is_load) begin
      len_mem[in_item.symbol]  <= len_sat;
      code_mem[in_item.symbol] <= in_item.code_bits;
    end
    if (accept && is_encode) begin
      rd_len_r  <= len_mem[in_item.symbol];
      rd_code_r <= code_mem[in_item.symbol];
      rd_vld_r  <= vld_r[in_item.symbol];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (accept && is_load) begin
      vld_nxt[in_item.symbol] = 1'b1;
    end
    if (accept && (is_encode || is_flush)) begin
      pend_nxt   = 1'b1;
      pflush_nxt = is_flush;
    end else begin
      pend_nxt   = pend_r && q_status.full;
      pflush_nxt = pflush_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      pend_r   <= 1'b0;
      pflush_r <= 1'b0;
    end else begin
      vld_r    <= vld_nxt;
      pend_r   <= pend_nxt;
      pflush_r <= pflush_nxt;
    end
  end

  // An entry never loaded reads as length zero; zero-length encodes are dropped here.
  assign len_eff = rd_vld_r ? rd_len_r : '0;
  assign push    = pend_r && !q_status.full && (pflush_r || (len_eff != '0));

  always_comb begin
    push_job.is_flush  = pflush_r;
    push_job.len       = len_eff;
    push_job.code_left = rd_code_r << (hux_pkg::LEN_W'(hux_pkg::CODE_W) - len_eff);
  end

endmodule

// ===== design/hux_queue.sv =====
// Small job queue between the front end and the bit packer back end.
// Depends on hux_pkg.
module hux_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hux_pkg::job_t       push_job,
  input  logic                pop,
  output hux_pkg::job_t       head,
  output hux_pkg::q_status_t  q_status
);

  hux_pkg::job_t entry_r [hux_pkg::Q_DEPTH];
  logic [hux_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [hux_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [hux_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + hux_pkg::Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + hux_pkg::Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + hux_pkg::Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - hux_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign head           = entry_r[rd_ptr_r];
  assign q_status.full  = (cnt_r == hux_pkg::Q_CNT_W'(hux_pkg::Q_DEPTH));
  assign q_status.empty = (cnt_r == '0);

endmodule

// ===== design/hux_back.sv =====
// Back end: merges codes into the pending bits and sends bytes and pad counts.
// Depends on hux_pkg.
module hux_back (
  input  logic                clk,
  input  logic                rst_n,
  input  hux_pkg::q_status_t  q_status,
  input  hux_pkg::job_t       head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output hux_pkg::out_item_t  out_item
);

  hux_pkg::back_state_t state_r, state_nxt;

  logic [hux_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [hux_pkg::LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [hux_pkg::BYTE_W-1:0] pb_r, pb_nxt;
  logic [hux_pkg::PC_W-1:0]   pc_r, pc_nxt;
  logic [hux_pkg::PC_W-1:0]   pad_r, pad_nxt;
  logic                       out_valid_r, out_valid_nxt;
  hux_pkg::out_item_t         out_item_r, out_item_nxt;

  logic                       can_emit, emit, short_code, tail_run;
  hux_pkg::out_item_t         emit_item;
  logic [hux_pkg::LEN_W-1:0]  total;
  logic [hux_pkg::ACC_W-1:0]  joined;

  assign can_emit = !out_valid_r || !out_stall;

  // Pending bits and the new code, both left-aligned, joined into one word.
  assign total  = hux_pkg::LEN_W'(pc_r) + head.len;
  assign joined = {pb_r, {hux_pkg::CODE_W{1'b0}}} |
                  ({head.code_left, {hux_pkg::BYTE_W{1'b0}}} >> pc_r);
  assign short_code = (total <= hux_pkg::LEN_W'(hux_pkg::BYTE_W));
  assign tail_run   = (cnt_r <= hux_pkg::LEN_W'(2 * hux_pkg::BYTE_W));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hux_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          if (head.is_flush) begin
            if (can_emit) begin
              state_nxt = hux_pkg::BK_PAD;
            end
          end else if (!short_code) begin
            state_nxt = hux_pkg::BK_SHIFT;
          end
        end
      end
      hux_pkg::BK_SHIFT: begin
        if (can_emit && tail_run) begin
          state_nxt = hux_pkg::BK_IDLE;
        end
      end
      hux_pkg::BK_PAD: begin
        if (can_emit) begin
          state_nxt = hux_pkg::BK_IDLE;
        end
      end
      default: state_nxt = hux_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    emit      = 1'b0;
    emit_item = '0;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    pb_nxt    = pb_r;
    pc_nxt    = pc_r;
    pad_nxt   = pad_r;
    unique case (state_r)
      hux_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          if (head.is_flush) begin
            if (can_emit) begin
              pop                = 1'b1;
              emit               = 1'b1;
              emit_item.out_byte = pb_r;
              pad_nxt            = hux_pkg::PC_W'(hux_pkg::BYTE_W) - pc_r;
              pb_nxt             = '0;
              pc_nxt             = '0;
            end
          end else begin
            pop     = 1'b1;
            acc_nxt = joined;
            cnt_nxt = total;
            if (short_code) begin
              pb_nxt = joined[hux_pkg::ACC_W-1 -: hux_pkg::BYTE_W];
              pc_nxt = total[hux_pkg::PC_W-1:0];
            end
          end
        end
      end
      hux_pkg::BK_SHIFT: begin
        if (can_emit) begin
          emit                  = 1'b1;
          emit_item.out_byte    = acc_r[hux_pkg::ACC_W-1 -: hux_pkg::BYTE_W];
          emit_item.last_of_run = tail_run;
          acc_nxt               = acc_r << hux_pkg::BYTE_W;
          cnt_nxt               = cnt_r - hux_pkg::LEN_W'(hux_pkg::BYTE_W);
          if (tail_run) begin
            pb_nxt = acc_r[hux_pkg::ACC_W-hux_pkg::BYTE_W-1 -: hux_pkg::BYTE_W];
            pc_nxt = hux_pkg::PC_W'(cnt_r - hux_pkg::LEN_W'(hux_pkg::BYTE_W));
          end
        end
      end
      hux_pkg::BK_PAD: begin
        if (can_emit) begin
          emit                   = 1'b1;
          emit_item.out_byte     = hux_pkg::BYTE_W'(pad_r);
          emit_item.is_pad_count = 1'b1;
          emit_item.last_of_run  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = emit_item;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    cnt_r      <= cnt_nxt;
    pad_r      <= pad_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hux_pkg::BK_IDLE;
      pb_r        <= '0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pb_r        <= pb_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== design/hux_checker.sv =====
// Port-level checker for the Huffman bit packer, bound to the top level.
// Depends on hux_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hux_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input hux_pkg::out_item_t out_item
);

  logic out_wait;
  logic out_take;
  logic pad_seen;
  logic pad_ok;

  assign out_wait = out_valid && out_stall;
  assign out_take = out_valid && !out_stall;
  assign pad_seen = out_valid && out_item.is_pad_count;
  assign pad_ok   = (out_item.out_byte <= 8'd8) && out_item.last_of_run;

  // A stalled result transaction holds.
  `HUX_ASSERT(a_out_hold, out_wait |=> out_valid && $stable(out_item), "held result moved")

  // Reset leaves no result pending and the input open.
  `HUX_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_valid && !in_stall, "reset did not clear")

  // A pad count is at most eight and closes its run.
  `HUX_ASSERT(a_pad_form, pad_seen |-> pad_ok, "bad pad count")

  // A pad count is always preceded by its padded byte, so two never follow.
  `HUX_ASSERT(a_pad_pair, out_take && out_item.is_pad_count |=> !pad_seen, "pad count repeated")

endmodule

bind huffman_bit_packer hux_checker u_hux_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
